[hdl/temperature_reading_statistics_defines.svh]
// assertion helpers used by the top-level file that checks the block
`ifndef TEMPERATURE_READING_STATISTICS_DEFINES_SVH
`define TEMPERATURE_READING_STATISTICS_DEFINES_SVH

// same-cycle implication, off during reset
`define TRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define TRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/trs_pkg.sv]
package trs_pkg;

   localparam int RAW_W     = 12;
   localparam int VAL_W     = 11;
   localparam int CNT_W     = 13;
   localparam int SUM_W     = 23;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 11;
   localparam int BAND_W    = 2;
   localparam int NUM_BANDS = 4;

   localparam int CNT_MAX           = 8191;
   localparam int MAX_READINGS_DEF  = 4096;
   localparam int QUEUE_DEPTH_DEF   = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_LEVEL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WARNING_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_LIMIT = 2'd3;

   localparam logic [CSR_W-1:0] ALARM_LEVEL_RST    = 11'd450;
   localparam logic [CSR_W-1:0] NORMAL_LIMIT_RST   = 11'd290;
   localparam logic [CSR_W-1:0] WARNING_LIMIT_RST  = 11'd440;
   localparam logic [CSR_W-1:0] CRITICAL_LIMIT_RST = 11'd590;

   // band codes
   localparam logic [BAND_W-1:0] BAND_NORMAL   = 2'd0;
   localparam logic [BAND_W-1:0] BAND_WARNING  = 2'd1;
   localparam logic [BAND_W-1:0] BAND_CRITICAL = 2'd2;
   localparam logic [BAND_W-1:0] BAND_SHUTDOWN = 2'd3;

   typedef struct packed {
      logic signed [RAW_W-1:0] reading;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] min_reading;
      logic [VAL_W-1:0] max_reading;
      logic [VAL_W-1:0] avg_reading;
      logic [CNT_W-1:0] valid_count;
      logic [CNT_W-1:0] error_count;
      logic [CNT_W-1:0] first_alarm_position;
      logic [VAL_W-1:0] first_alarm_value;
      logic [CNT_W-1:0] normal_count;
      logic [CNT_W-1:0] warning_count;
      logic [CNT_W-1:0] critical_count;
      logic [CNT_W-1:0] shutdown_count;
      logic             none_valid;
   } rsp_type;

   // classified reading as it sits in the queue
   typedef struct packed {
      logic              last;
      logic              err;
      logic              ge_alarm;
      logic [BAND_W-1:0] band;
      logic [VAL_W-1:0]  value;
   } entry_type;

   typedef struct packed {
      logic div_start;
      logic div_busy;
      logic snap_pending;
   } back_status_type;

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c,
                                             input logic [CNT_W-1:0] cap);
      return (c < cap) ? c + 1'b1 : c;
   endfunction

endpackage

[hdl/temperature_reading_statistics.sv]
// Batch statistics over temperature readings in tenths of a degree. Readings enter on the
// req_ channel, one per cycle while req_stall is low; req_data.last closes a batch, and one
// rsp_ transaction then carries min, max, rounded average, counts, the first alarm reading and
// the four band counts. Negative readings are counted as errors only. Readings are classified
// against the csr_ limits on entry and queued (QUEUE_DEPTH entries) ahead of the accumulator,
// which takes one reading a cycle unless a final reading is held back. The average comes
// from a restoring divider that yields one quotient bit a cycle; a following batch streams on
// meanwhile, but its final reading holds in the queue until the previous result has moved
// into the output register. Counters saturate at MAX_READINGS (at most 8191). The user must
// write limits only while the block is idle; the block itself does not enforce this.
`include "temperature_reading_statistics_defines.svh"

module temperature_reading_statistics #(
   parameter int MAX_READINGS = trs_pkg::MAX_READINGS_DEF,
   parameter int QUEUE_DEPTH  = trs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [trs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [trs_pkg::CSR_W-1:0]     csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  trs_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output trs_pkg::rsp_type              rsp_data
);

   logic                     push, pop, q_full, head_valid;
   trs_pkg::entry_type       entry, head_data;
   trs_pkg::back_status_type stat;

   assign req_stall = q_full;

   trs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .q_full      (q_full),
      .push        (push),
      .entry       (entry)
   );

   trs_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (entry),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   trs_back #(
      .MAX_READINGS (MAX_READINGS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .status     (stat)
   );

   `TRS_ASSERT_IMPL(a_no_snap_overwrite, clock, reset, stat.div_start, !stat.snap_pending, "final reading taken while a result is pending")
   `TRS_ASSERT_NEXT(a_div_runs, clock, reset, stat.div_start, stat.div_busy && stat.snap_pending, "divider did not start")
   `TRS_ASSERT_IMPL(a_empty_batch, clock, reset, rsp_valid && rsp_data.none_valid, rsp_data.min_reading == 0 && rsp_data.max_reading == 0 && rsp_data.avg_reading == 0 && rsp_data.first_alarm_position == 0, "empty batch with nonzero statistics")
   `TRS_ASSERT_IMPL(a_min_max, clock, reset, rsp_valid && !rsp_data.none_valid, rsp_data.min_reading <= rsp_data.max_reading, "min above max")

endmodule

[hdl/trs_front.sv]
module trs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [trs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [trs_pkg::CSR_W-1:0]        csr_wr_data,
   input  logic                             req_valid,
   input  trs_pkg::req_type                 req_data,
   input  logic                             q_full,
   output logic                             push,
   output trs_pkg::entry_type               entry
);

   logic [trs_pkg::CSR_W-1:0] alarm_ff, alarm_in;
   logic [trs_pkg::CSR_W-1:0] normal_ff, normal_in;
   logic [trs_pkg::CSR_W-1:0] warning_ff, warning_in;
   logic [trs_pkg::CSR_W-1:0] critical_ff, critical_in;
   logic [trs_pkg::VAL_W-1:0] value;

   always_comb begin
      alarm_in    = alarm_ff;
      normal_in   = normal_ff;
      warning_in  = warning_ff;
      critical_in = critical_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            trs_pkg::CSR_ALARM_LEVEL:    alarm_in    = csr_wr_data;
            trs_pkg::CSR_NORMAL_LIMIT:   normal_in   = csr_wr_data;
            trs_pkg::CSR_WARNING_LIMIT:  warning_in  = csr_wr_data;
            trs_pkg::CSR_CRITICAL_LIMIT: critical_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff    <= trs_pkg::ALARM_LEVEL_RST;
         normal_ff   <= trs_pkg::NORMAL_LIMIT_RST;
         warning_ff  <= trs_pkg::WARNING_LIMIT_RST;
         critical_ff <= trs_pkg::CRITICAL_LIMIT_RST;
      end else begin
         alarm_ff    <= alarm_in;
         normal_ff   <= normal_in;
         warning_ff  <= warning_in;
         critical_ff <= critical_in;
      end
   end

   assign value = req_data.reading[trs_pkg::VAL_W-1:0];
   assign push  = req_valid && !q_full;

   always_comb begin
      entry.last     = req_data.last;
      entry.err      = req_data.reading[trs_pkg::RAW_W-1];
      entry.ge_alarm = (value >= alarm_ff);
      entry.value    = value;
      // first band test that holds wins, even with unordered limits
      if (value <= normal_ff) begin
         entry.band = trs_pkg::BAND_NORMAL;
      end else if (value <= warning_ff) begin
         entry.band = trs_pkg::BAND_WARNING;
      end else if (value <= critical_ff) begin
         entry.band = trs_pkg::BAND_CRITICAL;
      end else begin
         entry.band = trs_pkg::BAND_SHUTDOWN;
      end
   end

endmodule

[hdl/trs_fifo.sv]
module trs_fifo #(
   parameter int DEPTH = trs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  trs_pkg::entry_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output trs_pkg::entry_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   trs_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/trs_back.sv]
module trs_back #(
   parameter int MAX_READINGS = trs_pkg::MAX_READINGS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  trs_pkg::entry_type       head_data,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output trs_pkg::rsp_type         rsp_data,
   output trs_pkg::back_status_type status
);

   localparam int VW = trs_pkg::VAL_W;
   localparam int CW = trs_pkg::CNT_W;
   localparam int SW = trs_pkg::SUM_W;
   localparam int DIV_W = SW + 1;
   localparam int DCNT_W = $clog2(DIV_W);
   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_W - 1);
   localparam logic [CW-1:0] CNT_CAP = (MAX_READINGS > trs_pkg::CNT_MAX) ?
                                       CW'(trs_pkg::CNT_MAX) : CW'(MAX_READINGS);

   // batch state
   logic [SW-1:0] sum_ff, sum_in, sum_nx;
   logic [VW-1:0] min_ff, min_in, min_nx;
   logic [VW-1:0] max_ff, max_in, max_nx;
   logic          seen_ff, seen_in, seen_nx;
   logic [CW-1:0] pos_ff, pos_in, pos_nx;
   logic [CW-1:0] vtot_ff, vtot_in, vtot_nx;
   logic [CW-1:0] etot_ff, etot_in, etot_nx;
   logic [CW-1:0] apos_ff, apos_in, apos_nx;
   logic [VW-1:0] aval_ff, aval_in, aval_nx;
   logic [CW-1:0] band_ff [trs_pkg::NUM_BANDS];
   logic [CW-1:0] band_in [trs_pkg::NUM_BANDS];
   logic [CW-1:0] band_nx [trs_pkg::NUM_BANDS];

   // average divider and the finished batch waiting on it
   logic              div_busy_ff, div_busy_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [CW-1:0]     div_rem_ff, div_rem_in;
   logic [DIV_W-1:0]  div_quo_ff, div_quo_in;
   logic [CW-1:0]     div_den_ff, div_den_in;
   logic [CW:0]       rem_sh;
   logic              snap_pending_ff, snap_pending_in;
   trs_pkg::rsp_type  snap_ff, snap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   trs_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [DIV_W-1:0] sum_wide;
   logic             start, move, ok;
   logic [VW-1:0]    avg;

   assign ok    = !head_data.err;
   // a final reading waits until the previous result has moved into the output register
   assign pop   = head_valid && (!head_data.last || !snap_pending_ff);
   assign start = pop && head_data.last;
   assign move  = snap_pending_ff && !div_busy_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      pos_nx   = trs_pkg::bump(pos_ff, CNT_CAP);
      etot_nx  = ok ? etot_ff : trs_pkg::bump(etot_ff, CNT_CAP);
      vtot_nx  = ok ? trs_pkg::bump(vtot_ff, CNT_CAP) : vtot_ff;
      seen_nx  = seen_ff || ok;
      min_nx   = min_ff;
      max_nx   = max_ff;
      if (ok && (!seen_ff || head_data.value < min_ff)) min_nx = head_data.value;
      if (ok && (!seen_ff || head_data.value > max_ff)) max_nx = head_data.value;
      sum_wide = {1'b0, sum_ff} + DIV_W'(head_data.value);
      sum_nx   = sum_ff;
      if (ok) sum_nx = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
      apos_nx  = apos_ff;
      aval_nx  = aval_ff;
      if (ok && apos_ff == '0 && head_data.ge_alarm) begin
         apos_nx = pos_nx;
         aval_nx = head_data.value;
      end
      for (int b = 0; b < trs_pkg::NUM_BANDS; b++) begin
         band_nx[b] = (ok && head_data.band == trs_pkg::BAND_W'(b)) ?
                      trs_pkg::bump(band_ff[b], CNT_CAP) : band_ff[b];
      end
   end

   always_comb begin
      sum_in  = sum_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      seen_in = seen_ff;
      pos_in  = pos_ff;
      vtot_in = vtot_ff;
      etot_in = etot_ff;
      apos_in = apos_ff;
      aval_in = aval_ff;
      for (int b = 0; b < trs_pkg::NUM_BANDS; b++) band_in[b] = band_ff[b];
      if (pop) begin
         if (head_data.last) begin
            sum_in  = '0;
            min_in  = '0;
            max_in  = '0;
            seen_in = 1'b0;
            pos_in  = '0;
            vtot_in = '0;
            etot_in = '0;
            apos_in = '0;
            aval_in = '0;
            for (int b = 0; b < trs_pkg::NUM_BANDS; b++) band_in[b] = '0;
         end else begin
            sum_in  = sum_nx;
            min_in  = min_nx;
            max_in  = max_nx;
            seen_in = seen_nx;
            pos_in  = pos_nx;
            vtot_in = vtot_nx;
            etot_in = etot_nx;
            apos_in = apos_nx;
            aval_in = aval_nx;
            for (int b = 0; b < trs_pkg::NUM_BANDS; b++) band_in[b] = band_nx[b];
         end
      end
   end

   // restoring divider, one quotient bit a cycle
   always_comb begin
      div_busy_in = div_busy_ff;
      div_cnt_in  = div_cnt_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_den_in  = div_den_ff;
      rem_sh      = {div_rem_ff, div_quo_ff[DIV_W-1]};
      snap_in     = snap_ff;
      if (start) begin
         div_busy_in = 1'b1;
         div_cnt_in  = '0;
         div_rem_in  = '0;
         // rounding half up: add half the divisor first
         div_quo_in  = {1'b0, sum_nx} + DIV_W'(vtot_nx >> 1);
         div_den_in  = vtot_nx;
         snap_in.min_reading          = min_nx;
         snap_in.max_reading          = max_nx;
         snap_in.avg_reading          = '0;
         snap_in.valid_count          = vtot_nx;
         snap_in.error_count          = etot_nx;
         snap_in.first_alarm_position = apos_nx;
         snap_in.first_alarm_value    = aval_nx;
         snap_in.normal_count         = band_nx[trs_pkg::BAND_NORMAL];
         snap_in.warning_count        = band_nx[trs_pkg::BAND_WARNING];
         snap_in.critical_count       = band_nx[trs_pkg::BAND_CRITICAL];
         snap_in.shutdown_count       = band_nx[trs_pkg::BAND_SHUTDOWN];
         snap_in.none_valid           = (vtot_nx == '0);
      end else if (div_busy_ff) begin
         // the remainder stays below the divisor, so it fits the counter width
         if (rem_sh >= {1'b0, div_den_ff}) begin
            div_rem_in = rem_sh[CW-1:0] - div_den_ff;
            div_quo_in = {div_quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            div_rem_in = rem_sh[CW-1:0];
            div_quo_in = {div_quo_ff[DIV_W-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff + 1'b1;
         if (div_cnt_ff == DIV_LAST) div_busy_in = 1'b0;
      end
   end

   always_comb begin
      if (snap_ff.none_valid) begin
         avg = '0;
      end else if (|div_quo_ff[DIV_W-1:VW]) begin
         avg = {VW{1'b1}};
      end else begin
         avg = div_quo_ff[VW-1:0];
      end
      rsp_data_in = rsp_data_ff;
      if (move) begin
         rsp_data_in             = snap_ff;
         rsp_data_in.avg_reading = avg;
      end
      rsp_valid_in    = move || (rsp_valid_ff && rsp_stall);
      snap_pending_in = start ? 1'b1 : (move ? 1'b0 : snap_pending_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff          <= '0;
         min_ff          <= '0;
         max_ff          <= '0;
         seen_ff         <= 1'b0;
         pos_ff          <= '0;
         vtot_ff         <= '0;
         etot_ff         <= '0;
         apos_ff         <= '0;
         aval_ff         <= '0;
         for (int b = 0; b < trs_pkg::NUM_BANDS; b++) band_ff[b] <= '0;
         div_busy_ff     <= 1'b0;
         div_cnt_ff      <= '0;
         snap_pending_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sum_ff          <= sum_in;
         min_ff          <= min_in;
         max_ff          <= max_in;
         seen_ff         <= seen_in;
         pos_ff          <= pos_in;
         vtot_ff         <= vtot_in;
         etot_ff         <= etot_in;
         apos_ff         <= apos_in;
         aval_ff         <= aval_in;
         for (int b = 0; b < trs_pkg::NUM_BANDS; b++) band_ff[b] <= band_in[b];
         div_busy_ff     <= div_busy_in;
         div_cnt_ff      <= div_cnt_in;
         snap_pending_ff <= snap_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      snap_ff     <= snap_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_data_ff;
   assign status.div_start    = start;
   assign status.div_busy     = div_busy_ff;
   assign status.snap_pending = snap_pending_ff;

endmodule

[bench/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import trs_pkg::*;

   localparam int COUNT_CAP = (MAX_READINGS_DEF > CNT_MAX) ? CNT_MAX : MAX_READINGS_DEF;
   localparam logic [SUM_W-1:0] SUM_CAP = '1;
   localparam int VALUE_CAP        = (1 << VAL_W) - 1;
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS      = 230;
   localparam int WATCHDOG_NS      = 3_000_000;
   localparam int DIRECTED_COUNT   = 22;

   // band edges, alarm edge, error extremes, empty batches, lone readings, rounding half up
   localparam int DIRECTED_VALS[DIRECTED_COUNT] = '{
      0, 290, 291, 440, 441, 590, 591, -1, 449, 450, 2047, -2048, 1000,
      -5, -2000, 0, 2047, -1, 450, 450, 5, 6};
   localparam bit DIRECTED_LAST[DIRECTED_COUNT] = '{
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
      0, 1, 1, 1, 1, 0, 1, 0, 1};

   class batch_statistics_checker;
      logic [CSR_W-1:0] alarm_level, normal_limit, warning_limit, critical_limit;
      logic [SUM_W-1:0] running_total;
      logic [VAL_W-1:0] low_mark, high_mark, alarm_value;
      bit               any_valid;
      logic [CNT_W-1:0] position, valid_total, error_total, alarm_position;
      logic [CNT_W-1:0] band_tally[NUM_BANDS];
      rsp_type          pending_summaries[$];
      int               readings_seen, summaries_checked, failures;

      function new();
         alarm_level    = ALARM_LEVEL_RST;
         normal_limit   = NORMAL_LIMIT_RST;
         warning_limit  = WARNING_LIMIT_RST;
         critical_limit = CRITICAL_LIMIT_RST;
         readings_seen = 0;
         summaries_checked = 0;
         failures = 0;
         clear_batch();
      endfunction

      function void clear_batch();
         running_total = '0;
         low_mark = '0;
         high_mark = '0;
         alarm_value = '0;
         any_valid = 1'b0;
         position = '0;
         valid_total = '0;
         error_total = '0;
         alarm_position = '0;
         foreach (band_tally[b]) band_tally[b] = '0;
      endfunction

      function logic [CNT_W-1:0] saturating_inc(logic [CNT_W-1:0] c);
         return (c < COUNT_CAP) ? c + 1'b1 : c;
      endfunction

      function void set_limit(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] v);
         case (idx)
            CSR_ALARM_LEVEL:    alarm_level = v;
            CSR_NORMAL_LIMIT:   normal_limit = v;
            CSR_WARNING_LIMIT:  warning_limit = v;
            CSR_CRITICAL_LIMIT: critical_limit = v;
         endcase
      endfunction

      function void note_reading(req_type t);
         logic [VAL_W-1:0]  v;
         logic [BAND_W-1:0] band;
         int unsigned       mean;
         rsp_type           s;
         readings_seen++;
         position = saturating_inc(position);
         if (t.reading[RAW_W-1]) begin
            error_total = saturating_inc(error_total);
         end else begin
            v = t.reading[VAL_W-1:0];
            if (!any_valid || v < low_mark) low_mark = v;
            if (!any_valid || v > high_mark) high_mark = v;
            any_valid = 1'b1;
            if (SUM_CAP - running_total < v) running_total = SUM_CAP;
            else running_total = running_total + v;
            valid_total = saturating_inc(valid_total);
            // position is already past its saturating step here
            if (alarm_position == 0 && v >= alarm_level) begin
               alarm_position = position;
               alarm_value = v;
            end
            if (v <= normal_limit) band = BAND_NORMAL;
            else if (v <= warning_limit) band = BAND_WARNING;
            else if (v <= critical_limit) band = BAND_CRITICAL;
            else band = BAND_SHUTDOWN;
            band_tally[band] = saturating_inc(band_tally[band]);
         end
         if (t.last) begin
            mean = 0;
            if (valid_total != 0) begin
               mean = (32'(running_total) + 32'(valid_total) / 2) / 32'(valid_total);
               if (mean > VALUE_CAP) mean = VALUE_CAP;
            end
            s.min_reading          = low_mark;
            s.max_reading          = high_mark;
            s.avg_reading          = mean[VAL_W-1:0];
            s.valid_count          = valid_total;
            s.error_count          = error_total;
            s.first_alarm_position = alarm_position;
            s.first_alarm_value    = alarm_value;
            s.normal_count         = band_tally[BAND_NORMAL];
            s.warning_count        = band_tally[BAND_WARNING];
            s.critical_count       = band_tally[BAND_CRITICAL];
            s.shutdown_count       = band_tally[BAND_SHUTDOWN];
            s.none_valid           = (valid_total == 0);
            pending_summaries.push_back(s);
            clear_batch();
         end
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_summary(rsp_type got);
         rsp_type want;
         if (pending_summaries.size() == 0) begin
            $display("%0t ns: result with no batch pending, expected nothing, got %h",
                     $time, got);
            failures++;
            return;
         end
         want = pending_summaries.pop_front();
         compare_field("min_reading", want.min_reading, got.min_reading);
         compare_field("max_reading", want.max_reading, got.max_reading);
         compare_field("avg_reading", want.avg_reading, got.avg_reading);
         compare_field("valid_count", want.valid_count, got.valid_count);
         compare_field("error_count", want.error_count, got.error_count);
         compare_field("first_alarm_position", want.first_alarm_position,
                       got.first_alarm_position);
         compare_field("first_alarm_value", want.first_alarm_value, got.first_alarm_value);
         compare_field("normal_count", want.normal_count, got.normal_count);
         compare_field("warning_count", want.warning_count, got.warning_count);
         compare_field("critical_count", want.critical_count, got.critical_count);
         compare_field("shutdown_count", want.shutdown_count, got.shutdown_count);
         compare_field("none_valid", want.none_valid, got.none_valid);
         summaries_checked++;
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wr_data;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;

   batch_statistics_checker stats;
   bit sender_gaps, receiver_gaps, hold_request;
   int batches_sent, stalled_cycles, limit_settings;

   temperature_reading_statistics DUT (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) stats.note_reading(req_data);
         if (req_valid && req_stall) stalled_cycles++;
         if (rsp_valid && !rsp_stall) stats.check_summary(rsp_data);
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 99) < 12) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #(WATCHDOG_NS);
      $display("timeout with %0d results still pending", stats.pending_summaries.size());
      $display("** temperature_reading_statistics: FAILED **");
      $finish;
   end

   function automatic logic signed [RAW_W-1:0] pick_reading(bit errors_only);
      int unsigned roll;
      int          v;
      roll = $urandom_range(0, 99);
      if (errors_only || roll < 15) return RAW_W'($urandom_range(2048, 4095));
      if (roll < 35) begin
         // land close to one of the current edges
         case ($urandom_range(0, 3))
            0:       v = int'(stats.alarm_level);
            1:       v = int'(stats.normal_limit);
            2:       v = int'(stats.warning_limit);
            default: v = int'(stats.critical_limit);
         endcase
         v = v + int'($urandom_range(0, 4)) - 2;
         if (v < 0) v = 0;
         else if (v > VALUE_CAP) v = VALUE_CAP;
         return RAW_W'(v);
      end
      if (roll < 45) return roll[0] ? RAW_W'(0) : RAW_W'(VALUE_CAP);
      return RAW_W'($urandom_range(0, VALUE_CAP));
   endfunction

   task automatic send_reading(input logic signed [RAW_W-1:0] r, input logic lst,
                               input bit gappy);
      req_type t;
      if (gappy && sender_gaps && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      t.reading = r;
      t.last = lst;
      req_data <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random_batches(input int items);
      int sent, len, roll;
      bit errors_only, gappy;
      sent = 0;
      while (sent < items) begin
         roll = $urandom_range(0, 99);
         len = (roll < 70) ? $urandom_range(1, 8) :
               (roll < 95) ? $urandom_range(9, 40) : $urandom_range(41, 120);
         errors_only = ($urandom_range(0, 99) < 5);
         gappy = ($urandom_range(0, 9) < 7);
         for (int k = 0; k < len; k++) send_reading(pick_reading(errors_only), k == len - 1, gappy);
         sent += len;
         batches_sent++;
      end
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx, input int v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= CSR_W'(v);
      stats.set_limit(idx, CSR_W'(v));
      @(negedge clock);
   endtask

   task automatic program_limits(input int alarm, input int normal, input int warning,
                                 input int critical);
      write_limit(CSR_ALARM_LEVEL, alarm);
      write_limit(CSR_NORMAL_LIMIT, normal);
      write_limit(CSR_WARNING_LIMIT, warning);
      write_limit(CSR_CRITICAL_LIMIT, critical);
      csr_wr_en <= 1'b0;
      limit_settings++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (stats.pending_summaries.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      stats = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      hold_request = 1'b0;
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      batches_sent = 0;
      stalled_cycles = 0;
      limit_settings = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // limits still at their reset values
      for (int k = 0; k < DIRECTED_COUNT; k++)
         send_reading(RAW_W'(DIRECTED_VALS[k]), DIRECTED_LAST[k], 1'b1);
      batches_sent += 7;
      drain();

      program_limits(0, 0, 0, 0);
      run_random_batches(PHASE_ITEMS);
      drain();

      program_limits(VALUE_CAP, VALUE_CAP, VALUE_CAP, VALUE_CAP);
      run_random_batches(PHASE_ITEMS);
      drain();

      // limits out of order
      program_limits(1000, 1500, 300, 800);
      run_random_batches(PHASE_ITEMS);
      drain();

      // receiver holds off long enough for the input side to back up
      program_limits(600, 250, 500, 900);
      hold_request = 1'b1;
      run_random_batches(PHASE_ITEMS);
      drain();

      program_limits($urandom_range(0, VALUE_CAP), $urandom_range(0, VALUE_CAP),
                     $urandom_range(0, VALUE_CAP), $urandom_range(0, VALUE_CAP));
      run_random_batches(PHASE_ITEMS);
      drain();

      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      program_limits(1200, 400, 900, 1600);
      run_random_batches(PHASE_ITEMS);
      drain();

      $display("covered %0d readings in %0d batches under %0d limit settings, %0d results checked",
               stats.readings_seen, batches_sent, limit_settings, stats.summaries_checked);
      $display("input was held back for %0d cycles, including one long receiver hold-off",
               stalled_cycles);
      if (stats.failures == 0) $display("** temperature_reading_statistics: PASSED **");
      else $display("** temperature_reading_statistics: FAILED **");
      $finish;
   end

endmodule
